// ===== rtl/core/rgb_to_indexed_palette_builder_macros.svh =====
// Assertion helpers shared by the palette builder RTL.
// Both macros sample on the rising edge of i_clk and are quiet while i_rst_n is low.
`ifndef RGB_TO_INDEXED_PALETTE_BUILDER_MACROS_SVH
`define RGB_TO_INDEXED_PALETTE_BUILDER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define RTIP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define RTIP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rtip_pkg.sv =====
package rtip_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int KEY_W            = 24;
    localparam int BYTE_W           = 8;
    localparam int INDEX_W          = 8;
    localparam int SLOT_W           = 8;
    localparam int COUNT_W          = 9;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  pixel_rgb;
        logic              start_of_image;
        logic [SLOT_W-1:0] read_slot;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0] color_index;
        logic               overflow;
        logic [KEY_W-1:0]   stored_key;
        logic [COUNT_W-1:0] entries_used;
    } t_res;

    // Palette keys hold the pixel with its red and blue bytes exchanged.
    function automatic logic [KEY_W-1:0] swap_key(input logic [KEY_W-1:0] rgb);
        return {rgb[BYTE_W-1:0], rgb[2*BYTE_W-1:BYTE_W], rgb[3*BYTE_W-1:2*BYTE_W]};
    endfunction

endpackage

// ===== rtl/core/rtip_mem.sv =====
module rtip_mem #(
    parameter int DEPTH = rtip_pkg::PALETTE_SIZE_DEF,
    parameter int AW    = $clog2(rtip_pkg::PALETTE_SIZE_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [rtip_pkg::KEY_W-1:0] i_wdata,
    output logic [rtip_pkg::KEY_W-1:0] o_rdata
);
    import rtip_pkg::*;

    // Single-port palette store; the read data is registered.
    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rgb_to_indexed_palette_builder.sv =====
// Indexed palette builder: turns 24-bit 0xRRGGBB pixels into 8-bit palette indices, handing
// out indices in order of first appearance, and answers read requests for a stored palette
// slot together with the number of slots in use. Requests are handled one at a time. The
// palette lives in a single-port memory that gives one word per cycle, and the linear search
// through it sets the latency. A pixel's result waits until the search reaches the matching
// slot, or until every used slot has been compared and the insert step has run; when the
// palette is empty the pixel goes straight to the insert step. A read request waits for the
// memory read, or skips it when the slot lies at or beyond the count. The output register
// holds a finished result while the next request is taken, so a stalled output does not
// block the input until a second result is ready. No clearing pass is needed after reset:
// only slots below the count are ever read, and each of those has been written.

`include "rgb_to_indexed_palette_builder_macros.svh"

module rgb_to_indexed_palette_builder #(
    parameter int PALETTE_SIZE = rtip_pkg::PALETTE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rtip_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rtip_pkg::t_res o_out_res
);
    import rtip_pkg::*;

    // AW addresses one palette slot; CW holds counts from zero up to a full palette.
    localparam int AW = $clog2(PALETTE_SIZE);
    localparam int CW = $clog2(PALETTE_SIZE + 1);

    // Each request walks these steps, one per cycle while the output is not stalled.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_addr, n_addr;
    logic [KEY_W-1:0] r_key, n_key;
    t_res             r_res, n_res;
    t_res             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [KEY_W-1:0] mem_wdata;
    logic [KEY_W-1:0] mem_rdata;
    logic [CW-1:0]    count_start;
    logic [CW-1:0]    addr_ext;

    rtip_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // A new request is taken only while the sequencer is idle. The output register decouples
    // the result side, so a waiting result does not hold off the next request.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // The start flag resets the count in the same cycle that the request is taken, so the
    // search and the read check below always see the emptied palette.
    assign count_start = i_in_req.start_of_image ? '0 : r_count;
    // The next slot to search, widened so that the last slot does not wrap around.
    assign addr_ext    = CW'(r_addr) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_addr    = r_addr;
        mem_wdata   = r_key;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_count              = count_start;
                    n_key                = swap_key(i_in_req.pixel_rgb);
                    n_res                = '0;
                    n_res.entries_used   = COUNT_W'(count_start);
                    n_addr               = '0;
                    if (i_in_req.action == ACT_READ) begin
                        // Only slots below the count hold data; any other slot reads as zero.
                        if (COUNT_W'(i_in_req.read_slot) < COUNT_W'(count_start)) begin
                            mem_addr = i_in_req.read_slot[AW-1:0];
                            n_state  = S_RDWAIT;
                        end else begin
                            n_state  = S_DONE;
                        end
                    end else if (count_start == '0) begin
                        n_state  = S_INSERT;
                    end else begin
                        mem_addr = '0;
                        n_state  = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // The read data is for slot r_addr. The next slot is read while this one is
                // compared, so the search covers one slot per cycle.
                if (mem_rdata == r_key) begin
                    n_res.color_index = INDEX_W'(r_addr);
                    n_state           = S_DONE;
                end else if (addr_ext < r_count) begin
                    n_addr   = addr_ext[AW-1:0];
                    mem_addr = addr_ext[AW-1:0];
                end else begin
                    n_state  = S_INSERT;
                end
            end
            S_INSERT: begin
                // A new color takes the next free slot. If the palette is full, the color is
                // not stored; it gets index zero and the overflow flag.
                if (r_count < CW'(PALETTE_SIZE)) begin
                    mem_we             = 1'b1;
                    mem_addr           = r_count[AW-1:0];
                    n_count            = r_count + CW'(1);
                    n_res.color_index  = INDEX_W'(r_count[AW-1:0]);
                    n_res.entries_used = COUNT_W'(r_count + CW'(1));
                end else begin
                    n_res.overflow     = 1'b1;
                end
                n_state = S_DONE;
            end
            S_RDWAIT: begin
                n_res.stored_key = mem_rdata;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_key  <= n_key;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // The count of used slots never exceeds the palette size.
    `RTIP_ASSERT_IMP(a_count_limit, 1'b1, r_count <= CW'(PALETTE_SIZE), "palette count beyond size")
    // An overflow can be reported only when the palette is full.
    `RTIP_ASSERT_IMP(a_ovf_full, r_out_valid && r_out.overflow, r_out.entries_used == COUNT_W'(PALETTE_SIZE), "overflow below full palette")
    // Each write to the palette memory adds exactly one used slot.
    `RTIP_ASSERT_NXT(a_write_count, mem_we, r_count == $past(r_count) + CW'(1), "palette write without count step")
    // A read result never carries pixel fields.
    `RTIP_ASSERT_IMP(a_read_clean, r_out_valid && r_out.stored_key != '0, r_out.color_index == '0 && !r_out.overflow, "read result mixed with pixel fields")

endmodule
